FILE: design/pfe_pkg.sv
// Shared types, constants and tables of the postfix expression evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int VAL_W           = 48;
    localparam int DEN_W           = 50;
    localparam int DIG_W           = 4;
    localparam int DEF_STACK_DEPTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam logic [VAL_W-1:0] MAG_CAP = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CONV
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [VAL_W-1:0]  lhs;
        logic [VAL_W-1:0]  rhs;
        logic [VAL_W-1:0]  conv_num;
        logic [DEN_W-1:0]  conv_den;
        logic              conv_neg;
    } alu_req_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_DIV,
        AL_FIX,
        AL_DONE
    } alu_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_OP,
        ST_POPB,
        ST_POPA,
        ST_CHECK,
        ST_EXEC,
        ST_PUSH,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_MINUS,
        PH_NUM,
        PH_TOK,
        PH_DONE,
        PH_END,
        PH_FIN
    } phase_t;

    function automatic logic [DEN_W-1:0] pow10(input logic [DIG_W-1:0] n);
        logic [DEN_W-1:0] p;
        unique case (n)
            4'd0:  p = 50'd1;
            4'd1:  p = 50'd10;
            4'd2:  p = 50'd100;
            4'd3:  p = 50'd1000;
            4'd4:  p = 50'd10000;
            4'd5:  p = 50'd100000;
            4'd6:  p = 50'd1000000;
            4'd7:  p = 50'd10000000;
            4'd8:  p = 50'd100000000;
            4'd9:  p = 50'd1000000000;
            4'd10: p = 50'd10000000000;
            4'd11: p = 50'd100000000000;
            4'd12: p = 50'd1000000000000;
            4'd13: p = 50'd10000000000000;
            4'd14: p = 50'd100000000000000;
            4'd15: p = 50'd1000000000000000;
            default: p = 50'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: design/postfix_expression_evaluator.sv
// Top level: character parser, value stack and operator sequencer.
`timescale 1ns / 1ps
// Each character is taken in ST_IDLE and then stepped through the parser phases in ST_DISP.
// An operator or the end of a number waits on pfe_alu: a division or a number conversion runs
// the one bit-per-cycle long division, a multiply runs its 48-step shift-add instead, and an
// add or subtract needs neither.
// The last character adds up to one conversion or subtraction, then ST_FIN and ST_OUT before m_valid.
// Reset (aresetn low, synchronous) empties the stack and clears parser and output state.

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = pfe_pkg::DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_char_code,
    input  logic                              s_last_char,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pfe_pkg::VAL_W-1:0]  m_value,
    output logic                              m_error
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [VAL_W-1:0] INT_CAP = VAL_W'(1) << (VAL_W - 1 - FRAC_BITS);

    // Sequencer and parser state.
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic [DIG_W-1:0]  frac_reg, frac_next;
    logic              in_num_reg, in_num_next;
    logic              in_frac_reg, in_frac_next;
    logic              neg_reg, neg_next;
    logic              pend_reg, pend_next;
    logic              err_reg, err_next;

    // Operand and result holding.
    alu_op_t           op_reg, op_next;
    logic [VAL_W-1:0]  a_reg, a_next;
    logic [VAL_W-1:0]  b_reg, b_next;
    logic [VAL_W-1:0]  cnum_reg, cnum_next;
    logic [DEN_W-1:0]  cden_reg, cden_next;
    logic              cneg_reg, cneg_next;
    logic [VAL_W-1:0]  res_reg, res_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic              m_error_reg, m_error_next;

    // Stack memory.
    logic [VAL_W-1:0]  stack_mem [STACK_DEPTH];
    logic [VAL_W-1:0]  rdata_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    // Arithmetic unit.
    alu_req_t          alu_req;
    logic              alu_start;
    logic              alu_done;
    logic [VAL_W-1:0]  alu_result;

    // Character decode.
    logic              is_digit;
    logic [DIG_W-1:0]  digit;
    logic [VAL_W+3:0]  acc_x10;
    logic [VAL_W-1:0]  take_acc;
    logic [DIG_W-1:0]  take_frac;
    logic              out_free;

    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign digit    = DIG_W'(char_reg - CH_ZERO);
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (VAL_W+4)'(digit);
    assign out_free = !m_valid_reg || m_ready;

    // Append one decimal digit: clamp the integer part, drop excess fraction digits.
    always_comb begin
        take_acc  = acc_reg;
        take_frac = frac_reg;
        if (!in_frac_reg) begin
            take_acc = (acc_x10 > (VAL_W+4)'(INT_CAP)) ? INT_CAP : acc_x10[VAL_W-1:0];
        end else if ((frac_reg < DIG_W'(MAX_FRAC_DIGITS)) && (acc_x10[VAL_W+3:VAL_W] == '0)) begin
            take_acc  = acc_x10[VAL_W-1:0];
            take_frac = frac_reg + 1'b1;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (err_reg) begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end else begin
                    unique case (phase_reg)
                        PH_MINUS: begin
                            if (pend_reg && !is_digit) begin
                                state_next = ST_OP;
                            end
                        end
                        PH_NUM: begin
                            if (in_num_reg && !is_digit
                                && !((char_reg == CH_DOT) && !in_frac_reg)) begin
                                state_next = ST_CHECK;
                            end
                        end
                        PH_TOK: begin
                            if ((char_reg == CH_PLUS) || (char_reg == CH_STAR)
                                || (char_reg == CH_SLASH)) begin
                                state_next = ST_OP;
                            end
                        end
                        PH_DONE: begin
                            if (!last_reg) begin
                                state_next = ST_IDLE;
                            end
                        end
                        PH_END: begin
                            if (pend_reg) begin
                                state_next = ST_OP;
                            end else if (in_num_reg) begin
                                state_next = ST_CHECK;
                            end
                        end
                        PH_FIN: begin
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_OP: begin
                state_next = (count_reg < CNT_W'(2)) ? ST_DISP : ST_POPB;
            end
            ST_POPB: begin
                state_next = ST_POPA;
            end
            ST_POPA: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ((op_reg == OP_DIV) && (b_reg == '0)) ? ST_DISP : ST_EXEC;
            end
            ST_EXEC: begin
                if (alu_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                state_next = ST_DISP;
            end
            ST_FIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and control outputs.
    always_comb begin
        phase_next   = phase_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        frac_next    = frac_reg;
        in_num_next  = in_num_reg;
        in_frac_next = in_frac_reg;
        neg_next     = neg_reg;
        pend_next    = pend_reg;
        err_next     = err_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cnum_next    = cnum_reg;
        cden_next    = cden_reg;
        cneg_next    = cneg_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_error_next = m_error_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        alu_start    = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                char_next  = s_char_code;
                last_next  = s_last_char;
                phase_next = PH_MINUS;
            end
            ST_DISP: begin
                if (!err_reg) begin
                    unique case (phase_reg)
                        PH_MINUS: begin
                            phase_next = PH_NUM;
                            if (pend_reg) begin
                                pend_next = 1'b0;
                                if (is_digit) begin
                                    // Minus right before a digit: start a negative number.
                                    in_num_next  = 1'b1;
                                    in_frac_next = 1'b0;
                                    neg_next     = 1'b1;
                                    acc_next     = VAL_W'(digit);
                                    frac_next    = '0;
                                    phase_next   = PH_DONE;
                                end else begin
                                    op_next = OP_SUB;
                                end
                            end
                        end
                        PH_NUM: begin
                            phase_next = PH_TOK;
                            if (in_num_reg) begin
                                if (is_digit) begin
                                    acc_next   = take_acc;
                                    frac_next  = take_frac;
                                    phase_next = PH_DONE;
                                end else if ((char_reg == CH_DOT) && !in_frac_reg) begin
                                    in_frac_next = 1'b1;
                                    phase_next   = PH_DONE;
                                end else begin
                                    op_next      = OP_CONV;
                                    cnum_next    = acc_reg;
                                    cden_next    = pow10(frac_reg);
                                    cneg_next    = neg_reg;
                                    in_num_next  = 1'b0;
                                    in_frac_next = 1'b0;
                                    neg_next     = 1'b0;
                                    acc_next     = '0;
                                    frac_next    = '0;
                                end
                            end
                        end
                        PH_TOK: begin
                            phase_next = PH_DONE;
                            if (char_reg == CH_SPACE) begin
                                phase_next = PH_DONE;
                            end else if (is_digit) begin
                                in_num_next  = 1'b1;
                                in_frac_next = 1'b0;
                                neg_next     = 1'b0;
                                acc_next     = VAL_W'(digit);
                                frac_next    = '0;
                            end else if (char_reg == CH_MINUS) begin
                                pend_next = 1'b1;
                            end else if (char_reg == CH_PLUS) begin
                                op_next = OP_ADD;
                            end else if (char_reg == CH_STAR) begin
                                op_next = OP_MUL;
                            end else if (char_reg == CH_SLASH) begin
                                op_next = OP_DIV;
                            end else begin
                                err_next = 1'b1;
                            end
                        end
                        PH_DONE: begin
                            if (last_reg) begin
                                phase_next = PH_END;
                            end
                        end
                        PH_END: begin
                            phase_next = PH_FIN;
                            if (pend_reg) begin
                                pend_next = 1'b0;
                                op_next   = OP_SUB;
                            end else if (in_num_reg) begin
                                op_next      = OP_CONV;
                                cnum_next    = acc_reg;
                                cden_next    = pow10(frac_reg);
                                cneg_next    = neg_reg;
                                in_num_next  = 1'b0;
                                in_frac_next = 1'b0;
                                neg_next     = 1'b0;
                                acc_next     = '0;
                                frac_next    = '0;
                            end
                        end
                        PH_FIN: begin
                            phase_next = PH_FIN;
                        end
                        default: begin
                            phase_next = PH_FIN;
                        end
                    endcase
                end
            end
            ST_OP: begin
                // Underflow, else fetch the right operand from the top.
                if (count_reg < CNT_W'(2)) begin
                    err_next = 1'b1;
                end
                rd_addr = AW'(count_reg - 1'b1);
            end
            ST_POPB: begin
                b_next  = rdata_reg;
                rd_addr = AW'(count_reg - CNT_W'(2));
            end
            ST_POPA: begin
                a_next     = rdata_reg;
                count_next = count_reg - CNT_W'(2);
            end
            ST_CHECK: begin
                if ((op_reg == OP_DIV) && (b_reg == '0)) begin
                    err_next = 1'b1;
                end else begin
                    alu_start = 1'b1;
                end
            end
            ST_EXEC: begin
                if (alu_done) begin
                    res_next = alu_result;
                end
            end
            ST_PUSH: begin
                if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                    err_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ST_FIN: begin
                rd_addr = '0;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (err_reg || (count_reg != CNT_W'(1))) begin
                        m_value_next = '0;
                        m_error_next = 1'b1;
                    end else begin
                        m_value_next = rdata_reg;
                        m_error_next = 1'b0;
                    end
                    // Drop the expression state for the next one.
                    count_next   = '0;
                    acc_next     = '0;
                    frac_next    = '0;
                    in_num_next  = 1'b0;
                    in_frac_next = 1'b0;
                    neg_next     = 1'b0;
                    pend_next    = 1'b0;
                    err_next     = 1'b0;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        alu_req.op       = op_reg;
        alu_req.lhs      = a_reg;
        alu_req.rhs      = b_reg;
        alu_req.conv_num = cnum_reg;
        alu_req.conv_den = cden_reg;
        alu_req.conv_neg = cneg_reg;
    end

    pfe_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .req     (alu_req),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[AW'(count_reg)] <= res_reg;
        end
        rdata_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_MINUS;
            count_reg   <= '0;
            acc_reg     <= '0;
            frac_reg    <= '0;
            in_num_reg  <= 1'b0;
            in_frac_reg <= 1'b0;
            neg_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
            in_num_reg  <= in_num_next;
            in_frac_reg <= in_frac_next;
            neg_reg     <= neg_next;
            pend_reg    <= pend_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        char_reg    <= char_next;
        last_reg    <= last_next;
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        cnum_reg    <= cnum_next;
        cden_reg    <= cden_next;
        cneg_reg    <= cneg_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
        m_error_reg <= m_error_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_error = m_error_reg;

    // Stack never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // An error beat always carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_value == '0))
        else $error("error beat with nonzero value");

    // The arithmetic unit reports completion only while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == ST_EXEC))
        else $error("arithmetic done outside execute");

    // No new character is taken while the unit is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_start |=> !s_ready)
        else $error("input ready during arithmetic");

endmodule

FILE: design/pfe_alu.sv
// Iterative arithmetic unit: saturating add/sub, shift-add multiply, long division.
`timescale 1ns / 1ps

module pfe_alu #(
    parameter int FRAC_BITS = pfe_pkg::DEF_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  pfe_pkg::alu_req_t            req,
    output logic                         done,
    output logic [pfe_pkg::VAL_W-1:0]    result
);
    import pfe_pkg::*;

    localparam int NW     = VAL_W + FRAC_BITS;
    localparam int PROD_W = 2 * VAL_W;
    localparam int CNT_W  = $clog2(NW + 1);

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0]  ma_reg, ma_next;
    logic [VAL_W-1:0]  mb_reg, mb_next;
    logic [NW-1:0]     dvd_reg, dvd_next;
    logic [NW-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              is_mul_reg, is_mul_next;
    logic [VAL_W-1:0]  res_reg, res_next;

    logic [VAL_W-1:0]  abs_l, abs_r;
    logic [VAL_W:0]    sum;
    logic [DEN_W:0]    rem_sh;
    logic [VAL_W-1:0]  mag;
    logic              hi_ovf;

    assign abs_l = req.lhs[VAL_W-1] ? (~req.lhs + 1'b1) : req.lhs;
    assign abs_r = req.rhs[VAL_W-1] ? (~req.rhs + 1'b1) : req.rhs;
    assign rem_sh = {rem_reg, dvd_reg[NW-1]};

    always_comb begin
        sum = (req.op == OP_SUB)
            ? ({req.lhs[VAL_W-1], req.lhs} - {req.rhs[VAL_W-1], req.rhs})
            : ({req.lhs[VAL_W-1], req.lhs} + {req.rhs[VAL_W-1], req.rhs});
    end

    // Cap the magnitude at 2^47 before the sign goes on.
    always_comb begin
        if (is_mul_reg) begin
            hi_ovf = |acc_reg[PROD_W-1:VAL_W+FRAC_BITS];
            mag = (hi_ovf || (acc_reg[VAL_W+FRAC_BITS-1:FRAC_BITS] > MAG_CAP))
                ? MAG_CAP : acc_reg[VAL_W+FRAC_BITS-1:FRAC_BITS];
        end else begin
            hi_ovf = |quo_reg[NW-1:VAL_W-1];
            mag = hi_ovf ? MAG_CAP : quo_reg[VAL_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        is_mul_next = is_mul_reg;
        res_next    = res_reg;
        unique case (state_reg)
            AL_IDLE: begin
                if (start) begin
                    unique case (req.op)
                        OP_ADD, OP_SUB: begin
                            if (sum[VAL_W] != sum[VAL_W-1]) begin
                                res_next = sum[VAL_W] ? ~VAL_MAX : VAL_MAX;
                            end else begin
                                res_next = sum[VAL_W-1:0];
                            end
                            state_next = AL_DONE;
                        end
                        OP_MUL: begin
                            ma_next     = abs_l;
                            mb_next     = abs_r;
                            acc_next    = '0;
                            neg_next    = req.lhs[VAL_W-1] ^ req.rhs[VAL_W-1];
                            is_mul_next = 1'b1;
                            cnt_next    = CNT_W'(VAL_W);
                            state_next  = AL_MUL;
                        end
                        OP_DIV: begin
                            dvd_next    = {abs_l, {FRAC_BITS{1'b0}}};
                            den_next    = DEN_W'(abs_r);
                            neg_next    = req.lhs[VAL_W-1] ^ req.rhs[VAL_W-1];
                            rem_next    = '0;
                            quo_next    = '0;
                            is_mul_next = 1'b0;
                            cnt_next    = CNT_W'(NW);
                            state_next  = AL_DIV;
                        end
                        default: begin
                            dvd_next    = {req.conv_num, {FRAC_BITS{1'b0}}};
                            den_next    = req.conv_den;
                            neg_next    = req.conv_neg;
                            rem_next    = '0;
                            quo_next    = '0;
                            is_mul_next = 1'b0;
                            cnt_next    = CNT_W'(NW);
                            state_next  = AL_DIV;
                        end
                    endcase
                end
            end
            AL_MUL: begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (mb_reg[VAL_W-1] ? PROD_W'(ma_reg) : '0);
                mb_next  = {mb_reg[VAL_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = AL_FIX;
                end
            end
            AL_DIV: begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DEN_W-1:0];
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                dvd_next = {dvd_reg[NW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = AL_FIX;
                end
            end
            AL_FIX: begin
                if (neg_reg) begin
                    res_next = ~mag + 1'b1;
                end else begin
                    res_next = mag[VAL_W-1] ? VAL_MAX : mag;
                end
                state_next = AL_DONE;
            end
            AL_DONE: begin
                state_next = AL_IDLE;
            end
            default: begin
                state_next = AL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        is_mul_reg <= is_mul_next;
        res_reg    <= res_next;
    end

    assign done   = (state_reg == AL_DONE);
    assign result = res_reg;

endmodule

FILE: bench/tb_postfix_expression_evaluator.sv
// Self-checking testbench for the postfix expression evaluator.
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator;
    import pfe_pkg::*;

    localparam int    DEPTH      = DEF_STACK_DEPTH;
    localparam int    FB         = DEF_FRAC_BITS;
    localparam int    N_CHARS    = 1650;
    localparam int    IDLE_LIMIT = 6000;
    localparam int    LONG_HOLD  = 600;
    localparam longint V_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint V_MIN     = -V_MAX - 1;
    localparam logic [63:0] CAP47   = 64'd1 << 47;
    localparam logic [63:0] ACC_TOP = (64'd1 << 48) - 1;
    localparam logic [63:0] INT_LIM = 64'd1 << (47 - FB);

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             error;
    } eval_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [7:0]               s_char_code;
    logic                     s_last_char;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [VAL_W-1:0]  m_value;
    logic                     m_error;

    postfix_expression_evaluator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_error     (m_error)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    char_beat_t   char_q[$];
    eval_result_t expect_q[$];
    int           fail_count = 0;
    int           result_count = 0;
    bit           in_beat = 0;
    bit           out_beat = 0;

    // ------------------------------------------------------------------
    // Evaluator model: its own copy of the parser and stack state.
    // ------------------------------------------------------------------
    longint      ev_stack[DEPTH];
    int          ev_depth;
    logic [63:0] ev_accum;
    int          ev_frac;
    bit          ev_in_num, ev_in_frac, ev_neg, ev_minus, ev_err;

    task automatic ev_clear();
        ev_depth   = 0;
        ev_accum   = 0;
        ev_frac    = 0;
        ev_in_num  = 0;
        ev_in_frac = 0;
        ev_neg     = 0;
        ev_minus   = 0;
        ev_err     = 0;
    endtask

    function automatic longint sat48(longint v);
        return v > V_MAX ? V_MAX : (v < V_MIN ? V_MIN : v);
    endfunction

    function automatic longint signed_mag(logic [63:0] mag, bit neg);
        logic [63:0] m;
        m = mag > CAP47 ? CAP47 : mag;
        return sat48(neg ? -longint'(m) : longint'(m));
    endfunction

    // num * 2^FB / den, truncated, capped at 2^47
    function automatic logic [63:0] fix_div(logic [63:0] num, logic [63:0] den);
        logic [127:0] wide;
        if (num / den >= INT_LIM)
            return CAP47;
        wide = {64'd0, num} << FB;
        return 64'(wide / {64'd0, den});
    endfunction

    // (a * b) >> FB, truncated, capped at 2^47
    function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] wide;
        wide = ({64'd0, a} * {64'd0, b}) >> FB;
        return wide > {64'd0, CAP47} ? CAP47 : wide[63:0];
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    task automatic ev_push(longint v);
        if (ev_depth >= DEPTH)
            ev_err = 1;
        else begin
            ev_stack[ev_depth] = v;
            ev_depth++;
        end
    endtask

    task automatic ev_apply(logic [7:0] c);
        longint a, b, r;
        bit     neg;
        if (ev_depth < 2) begin
            ev_err = 1;
            return;
        end
        b = ev_stack[ev_depth - 1];
        a = ev_stack[ev_depth - 2];
        ev_depth -= 2;
        neg = (a < 0) != (b < 0);
        case (c)
            CH_PLUS:  r = sat48(a + b);
            CH_MINUS: r = sat48(a - b);
            CH_STAR:  r = signed_mag(fix_mul(abs64(a), abs64(b)), neg);
            default: begin
                if (b == 0) begin
                    ev_err = 1;
                    return;
                end
                r = signed_mag(fix_div(abs64(a), abs64(b)), neg);
            end
        endcase
        ev_push(r);
    endtask

    task automatic ev_digit(int d);
        logic [63:0] n;
        n = ev_accum * 10 + d;
        if (!ev_in_frac)
            ev_accum = n > INT_LIM ? INT_LIM : n;
        else if (ev_frac < MAX_FRAC_DIGITS && n <= ACC_TOP) begin
            ev_accum = n;
            ev_frac++;
        end
    endtask

    task automatic ev_start_num(bit neg, int d);
        ev_in_num  = 1;
        ev_in_frac = 0;
        ev_neg     = neg;
        ev_accum   = 0;
        ev_frac    = 0;
        ev_digit(d);
    endtask

    task automatic ev_end_num();
        logic [63:0] scale;
        logic [63:0] mag;
        scale = 1;
        for (int i = 0; i < ev_frac; i++)
            scale = scale * 10;
        mag        = fix_div(ev_accum, scale);
        ev_in_num  = 0;
        ev_in_frac = 0;
        ev_accum   = 0;
        ev_frac    = 0;
        ev_push(signed_mag(mag, ev_neg));
        ev_neg     = 0;
    endtask

    task automatic ev_char(logic [7:0] c);
        bit dig;
        dig = c >= CH_ZERO && c <= CH_NINE;
        if (ev_minus) begin
            ev_minus = 0;
            if (dig) begin
                ev_start_num(1, c - CH_ZERO);
                return;
            end
            ev_apply(CH_MINUS);
            if (ev_err)
                return;
        end
        if (ev_in_num) begin
            if (dig) begin
                ev_digit(c - CH_ZERO);
                return;
            end
            if (c == CH_DOT && !ev_in_frac) begin
                ev_in_frac = 1;
                return;
            end
            ev_end_num();
            if (ev_err)
                return;
        end
        if (c == CH_SPACE)
            return;
        if (dig)
            ev_start_num(0, c - CH_ZERO);
        else if (c == CH_MINUS)
            ev_minus = 1;
        else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH)
            ev_apply(c);
        else
            ev_err = 1;
    endtask

    // Advance the model by one beat; queue a result on the last character.
    task automatic ev_step(logic [7:0] c, logic last);
        eval_result_t res;
        bit           bad;
        if (!ev_err)
            ev_char(c);
        if (!last)
            return;
        if (!ev_err) begin
            if (ev_minus) begin
                ev_minus = 0;
                ev_apply(CH_MINUS);
            end else if (ev_in_num)
                ev_end_num();
        end
        bad       = ev_err || ev_depth != 1;
        res.error = bad;
        res.value = bad ? '0 : ev_stack[0][VAL_W-1:0];
        expect_q.push_back(res);
        ev_clear();
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_char(logic [7:0] c, logic last);
        char_beat_t b;
        b.code = c;
        b.last = last;
        char_q.push_back(b);
    endtask

    task automatic add_expr(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    function automatic string rand_number();
        string s;
        int    n;
        s = "";
        if ($urandom_range(0, 3) == 0)
            s = "-";
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 13) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        if ($urandom_range(0, 2) == 0) begin
            s = {s, "."};
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        end
        return s;
    endfunction

    function automatic string rand_op();
        case ($urandom_range(0, 3))
            0:       return "+";
            1:       return "-";
            2:       return "*";
            default: return "/";
        endcase
    endfunction

    // Well-formed expression with random content
    function automatic string rand_expr();
        string s;
        int    depth, steps;
        s     = "";
        depth = 0;
        steps = $urandom_range(1, 9);
        for (int i = 0; i < steps; i++) begin
            if (depth < 2 || (depth < 6 && $urandom_range(0, 1) == 0)) begin
                s = {s, (s.len() > 0) ? " " : "", rand_number()};
                depth++;
            end else begin
                s = {s, " ", rand_op()};
                depth--;
            end
        end
        while (depth > 1) begin
            s = {s, " ", rand_op()};
            depth--;
        end
        return s;
    endfunction

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            add_char(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    task automatic add_broken();
        string s;
        int    k;
        s = rand_expr();
        k = $urandom_range(0, s.len() - 1);
        for (int i = 0; i < s.len(); i++)
            add_char((i == k) ? 8'($urandom_range(0, 255)) : s[i], i == s.len() - 1);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending characters with random gaps.
    // ------------------------------------------------------------------
    bit         drv_busy = 0;
    int         drv_gap = 0;
    char_beat_t drv_cur;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_beat) begin
                // beat taken: drop it and draw the next gap
                in_beat  = 0;
                drv_busy = 0;
                drv_gap  = $urandom_range(0, 5);
                if ($urandom_range(0, 7) == 0)
                    drv_gap = 0;
            end
            if (!drv_busy) begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (char_q.size() > 0) begin
                    drv_cur  = char_q.pop_front();
                    drv_busy = 1;
                end
            end
            s_valid     <= drv_busy;
            s_char_code <= drv_cur.code;
            s_last_char <= drv_cur.last;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per result, plus one long hold-off so the
    // output backs up and the input stalls behind it.
    // ------------------------------------------------------------------
    int rcv_stall = 0;
    bit long_hold_done = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_beat) begin
                out_beat  = 0;
                rcv_stall = $urandom_range(0, 5);
                if (!long_hold_done && result_count == 8) begin
                    long_hold_done = 1;
                    rcv_stall      = LONG_HOLD;
                end
            end
            if (rcv_stall > 0)
                rcv_stall--;
            m_ready <= (rcv_stall == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input beats, check on output beats, watchdog.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cycles++;
            if (s_valid && s_ready) begin
                in_beat     = 1;
                idle_cycles = 0;
                ev_step(s_char_code, s_last_char);
            end
            if (m_valid && m_ready) begin
                eval_result_t want;
                out_beat    = 1;
                idle_cycles = 0;
                result_count++;
                if (expect_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result value=%0d error=%0b",
                             $time, m_value, m_error);
                end else begin
                    want = expect_q.pop_front();
                    if (m_error !== want.error) begin
                        fail_count++;
                        $display("%0t: error flag mismatch, expected %0b, got %0b",
                                 $time, want.error, m_error);
                    end
                    if (m_value !== want.value) begin
                        fail_count++;
                        $display("%0t: value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.value), m_value);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        string s;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = '0;
        s_last_char = 1'b0;
        m_ready     = 1'b0;
        ev_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: operators, signs, fractions and each error path
        add_expr("3 4 +");
        add_expr("10 3 -");
        add_expr("-2.5 4 *");
        add_expr("7 2 /");
        add_expr("-7 2 /");
        add_expr("1 0 /");
        add_expr("+");
        add_expr("1 2");
        add_expr("3. 1 +");
        add_expr("3.. 1 +");
        add_expr("5 2 -");
        add_expr("5 -2 -");
        add_expr("99999999999999 1 +");
        add_expr("0.12345678912345 2 *");
        add_expr("140000 140000 *");
        add_expr("-140000 140000 *");
        add_expr("1 0.00001 /");
        add_expr("3 4 + x");
        add_expr("1\t2 +");
        add_char(8'h31, 0);
        add_char(8'h00, 1);
        add_char(8'hFF, 1);
        add_expr(" ");
        add_expr("3");
        // push one value too many onto the stack
        s = "";
        for (int i = 0; i <= DEPTH; i++)
            s = {s, "1 "};
        add_expr({s, "+"});
        // exactly full stack, then fold it down
        s = "";
        for (int i = 0; i < DEPTH; i++)
            s = {s, "2 "};
        for (int i = 1; i < DEPTH; i++)
            s = {s, "+ "};
        add_expr(s);

        // random: mostly well-formed, the rest noise and broken expressions
        while (char_q.size() < N_CHARS) begin
            case ($urandom_range(0, 9))
                0:       add_noise();
                1:       add_broken();
                default: add_expr(rand_expr());
            endcase
        end

        // drain: all characters taken, all results checked, then settle
        while (char_q.size() > 0 || drv_busy || expect_q.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (fail_count == 0 && expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
